// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the chase camera basis RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CCB_ASSERT_IMPLY(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("ccb assertion failed");
`define CCB_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("ccb assertion failed");
`else
`define CCB_ASSERT_IMPLY(lbl, clk, rst, pre, post)
`define CCB_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// ----- rtl/ccb_pkg.sv -----
// Shared constants and types for the chase camera basis pipeline.
// No dependencies.
package ccb_pkg;
   localparam int CFB     = 16;           // coordinate fraction bits
   localparam int UFB     = 14;           // unit vector fraction bits
   localparam int COORD_W = 32;
   localparam int DIST_W  = 31;
   localparam int UNIT_W  = UFB + 2;
   localparam logic signed [UNIT_W-1:0] UNIT_ONE = UNIT_W'(2**UFB);
   localparam logic [63:0] SHORT_LIM = ((64'd1 << (2*CFB)) + 64'd999999) / 64'd1000000;
   // normalizer internals
   localparam int MN_W       = 30;        // normalized magnitude width
   localparam int SQ_W       = 2*MN_W + 2;
   localparam int SQ_RW      = MN_W + 1;
   localparam int QW         = UFB + 1;
   localparam int NW         = MN_W + UFB + 2;
   localparam int DW         = SQ_RW + 1;
   localparam int PRE_STAGES = 5;
   localparam int NORM_LAT   = PRE_STAGES + SQ_RW + QW + 1;
   // scaled offset: unit * distance or height * unit
   localparam int OFS_W = UNIT_W + DIST_W;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [UNIT_W-1:0]  unit_type;
endpackage

// ----- rtl/ccb_delay.sv -----
// Enabled delay line with a reset valid bit per tap.
// Depends on nothing.
module ccb_delay #(
   parameter int W     = 8,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_vld,
   input  logic [W-1:0] in_data,
   output logic         out_vld,
   output logic [W-1:0] out_data
);
   logic [W-1:0] data_ff [DEPTH];
   logic         vld_ff  [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
         for (int i = 1; i < DEPTH; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= in_data;
         for (int i = 1; i < DEPTH; i++) data_ff[i] <= data_ff[i-1];
      end
   end

   assign out_vld  = vld_ff[DEPTH-1];
   assign out_data = data_ff[DEPTH-1];
endmodule

// ----- rtl/ccb_isqrt.sv -----
// Pipelined floor square root, one result bit per stage.
// Depends on ccb_pkg.
module ccb_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_vld,
   input  logic [ccb_pkg::SQ_W-1:0]   in_val,
   output logic                       out_vld,
   output logic [ccb_pkg::SQ_RW-1:0]  out_root
);
   localparam int RW = ccb_pkg::SQ_RW;
   localparam int VW = ccb_pkg::SQ_W;
   localparam int EW = RW + 2;

   logic [EW-1:0] rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];
   logic [VW-1:0] val_ff  [RW];
   logic          vld_ff  [RW];

   for (genvar j = 0; j < RW; j++) begin : g_stage
      logic [EW-1:0] rem_src, rsh, trial, rem_in;
      logic [RW-1:0] root_src, root_in;
      logic [VW-1:0] val_src;
      logic          vld_src, ge;

      if (j == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign val_src  = in_val;
         assign vld_src  = in_vld;
      end else begin : g_next
         assign rem_src  = rem_ff[j-1];
         assign root_src = root_ff[j-1];
         assign val_src  = val_ff[j-1];
         assign vld_src  = vld_ff[j-1];
      end

      always_comb begin
         rsh     = {rem_src[RW-1:0], val_src[VW-1 -: 2]};
         trial   = {root_src, 2'b01};
         ge      = (rsh >= trial);
         rem_in  = ge ? (rsh - trial) : rsh;
         root_in = {root_src[RW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            val_ff[j]  <= val_src << 2;
         end
      end
   end

   assign out_vld  = vld_ff[RW-1];
   assign out_root = root_ff[RW-1];
endmodule

// ----- rtl/ccb_norm3.sv -----
// Pipelined 3-vector normalizer: magnitude, align, squares, sqrt, divide.
// Depends on ccb_pkg, ccb_delay and ccb_isqrt.
module ccb_norm3 #(
   parameter int IW = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_vld,
   input  logic [2:0][IW-1:0]               in_v,
   output logic                             out_vld,
   output logic [2:0][ccb_pkg::UNIT_W-1:0]  out_o
);
   localparam int MW  = ccb_pkg::MN_W;
   localparam int LPW = (IW > 1) ? $clog2(IW) : 1;
   localparam int SHW = IW + MW - 1;
   localparam int SQW = 2 * MW;
   localparam int SBW = 3 * MW + 4;
   localparam int QW  = ccb_pkg::QW;
   localparam int NW  = ccb_pkg::NW;
   localparam int DW  = ccb_pkg::DW;
   localparam int UW  = ccb_pkg::UNIT_W;

   // stage 1: magnitudes
   logic [2:0][IW-1:0] m1_ff;
   logic [2:0]         sg1_ff;
   logic               v1_ff;
   // stage 2: leading one position
   logic [2:0][IW-1:0] m2_ff;
   logic [2:0]         sg2_ff;
   logic [LPW-1:0]     lp2_ff, lp_in;
   logic               zr2_ff, v2_ff;
   logic [IW-1:0]      or_c;
   // stage 3: aligned magnitudes
   logic [2:0][MW-1:0] mn3_ff;
   logic [2:0]         sg3_ff;
   logic               zr3_ff, v3_ff;
   // stage 4: squares
   logic [2:0][SQW-1:0] sq4_ff;
   logic [2:0][MW-1:0]  mn4_ff;
   logic [2:0]          sg4_ff;
   logic                zr4_ff, v4_ff;
   // stage 5: sum of squares
   logic [ccb_pkg::SQ_W-1:0] sum5_ff;
   logic [2:0][MW-1:0]       mn5_ff;
   logic [2:0]               sg5_ff;
   logic                     zr5_ff, v5_ff;
   // after square root
   logic                      rv;
   logic [ccb_pkg::SQ_RW-1:0] root;
   logic [2:0][MW-1:0]        mnr;
   logic [2:0]                sgr;
   logic                      zrr;
   // divide stages
   logic [2:0][NW-1:0] rem_ff [QW];
   logic [2:0][QW-1:0] q_ff   [QW];
   logic [DW-1:0]      d_ff   [QW];
   logic [2:0]         sg_ff  [QW];
   logic               zr_ff  [QW];
   logic               vd_ff  [QW];
   // output
   logic [2:0][UW-1:0] o_ff;
   logic               vo_ff;

   always_comb begin
      or_c  = m1_ff[0] | m1_ff[1] | m1_ff[2];
      lp_in = '0;
      for (int i = 0; i < IW; i++) begin
         if (or_c[i]) lp_in = LPW'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_vld;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic [SHW-1:0] sh;
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            m1_ff[i]  <= in_v[i][IW-1] ? (~in_v[i] + IW'(1)) : in_v[i];
            sg1_ff[i] <= in_v[i][IW-1];
         end
         m2_ff  <= m1_ff;
         sg2_ff <= sg1_ff;
         lp2_ff <= lp_in;
         zr2_ff <= (or_c == '0);
         // put the leading one of the largest part at bit MW-1
         for (int i = 0; i < 3; i++) begin
            sh        = {m2_ff[i], {(MW-1){1'b0}}} >> lp2_ff;
            mn3_ff[i] <= sh[MW-1:0];
         end
         sg3_ff <= sg2_ff;
         zr3_ff <= zr2_ff;
         for (int i = 0; i < 3; i++) begin
            sq4_ff[i] <= SQW'(mn3_ff[i]) * SQW'(mn3_ff[i]);
         end
         mn4_ff  <= mn3_ff;
         sg4_ff  <= sg3_ff;
         zr4_ff  <= zr3_ff;
         sum5_ff <= ccb_pkg::SQ_W'(sq4_ff[0]) + ccb_pkg::SQ_W'(sq4_ff[1])
                    + ccb_pkg::SQ_W'(sq4_ff[2]);
         mn5_ff  <= mn4_ff;
         sg5_ff  <= sg4_ff;
         zr5_ff  <= zr4_ff;
      end
   end

   ccb_isqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (v5_ff),
      .in_val   (sum5_ff),
      .out_vld  (rv),
      .out_root (root)
   );

   ccb_delay #(.W(SBW), .DEPTH(ccb_pkg::SQ_RW)) u_side (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (v5_ff),
      .in_data  ({zr5_ff, sg5_ff, mn5_ff}),
      .out_vld  (),
      .out_data ({zrr, sgr, mnr})
   );

   // restoring divide of (2*m*unit + r) by 2*r, one quotient bit per stage
   for (genvar j = 0; j < QW; j++) begin : g_div
      logic [2:0][NW-1:0] rem_src, rem_in;
      logic [2:0][QW-1:0] q_src, q_in;
      logic [DW-1:0]      d_src;
      logic [NW-1:0]      dsh;
      logic [2:0]         sg_src;
      logic               zr_src, v_src;

      if (j == 0) begin : g_first
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem_src[i] = NW'({mnr[i], {QW{1'b0}}}) + NW'(root);
         end
         assign q_src  = '0;
         assign d_src  = {root, 1'b0};
         assign sg_src = sgr;
         assign zr_src = zrr;
         assign v_src  = rv;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign q_src   = q_ff[j-1];
         assign d_src   = d_ff[j-1];
         assign sg_src  = sg_ff[j-1];
         assign zr_src  = zr_ff[j-1];
         assign v_src   = vd_ff[j-1];
      end

      always_comb begin
         dsh = NW'(d_src) << (QW - 1 - j);
         for (int i = 0; i < 3; i++) begin
            if (rem_src[i] >= dsh) begin
               rem_in[i] = rem_src[i] - dsh;
               q_in[i]   = q_src[i] | (QW'(1) << (QW - 1 - j));
            end else begin
               rem_in[i] = rem_src[i];
               q_in[i]   = q_src[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vd_ff[j] <= 1'b0;
         end else if (en) begin
            vd_ff[j] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            q_ff[j]   <= q_in;
            d_ff[j]   <= d_src;
            sg_ff[j]  <= sg_src;
            zr_ff[j]  <= zr_src;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= vd_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      logic [UW-1:0] qx;
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            qx = UW'(q_ff[QW-1][i]);
            if (zr_ff[QW-1]) begin
               o_ff[i] <= '0;
            end else begin
               o_ff[i] <= sg_ff[QW-1][i] ? (~qx + UW'(1)) : qx;
            end
         end
      end
   end

   assign out_vld = vo_ff;
   assign out_o   = o_ff;
endmodule

// ----- rtl/chase_camera_basis_unit.sv -----
// Chase camera basis: camera position and unit front/right/up vectors.
// Accepts one item per cycle while the output is not stalled. Three chained
// 52-stage normalizers set the depth.
// A stalled output freezes the whole pipeline; req_tready follows it.
// Synchronous reset clears all valid bits; payload registers are not reset.
`include "assert_macros.svh"
module chase_camera_basis_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // target_x, target_y, target_z, heading_x, heading_y, heading_z,
   // follow_distance, follow_height, one zero pad bit
   input  logic [255:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // cam_x, cam_y, cam_z, front_x, front_y, front_z,
   // right_x, right_y, right_z, upv_x, upv_y, upv_z
   output logic [239:0] rsp_tdata
);
   localparam int CW   = ccb_pkg::COORD_W;
   localparam int UW   = ccb_pkg::UNIT_W;
   localparam int OW   = ccb_pkg::OFS_W;
   localparam int RS_W = OW - ccb_pkg::UFB + 1;
   localparam int SM_W = RS_W + 2;
   localparam int NL   = ccb_pkg::NORM_LAT;
   localparam int SA_W = 4 * CW + ccb_pkg::DIST_W;
   localparam int SB_W = 3 * CW + 2 * UW + 1;
   localparam int SC_W = 3 * CW + 3 * UW + 1;

   function automatic logic signed [RS_W-1:0] round_unit(input logic signed [OW-1:0] v);
      logic [OW-1:0]   mg;
      logic [RS_W-1:0] rr;
      mg = v[OW-1] ? (~v + OW'(1)) : v;
      rr = RS_W'((mg + (OW'(1) << (ccb_pkg::UFB - 1))) >> ccb_pkg::UFB);
      return v[OW-1] ? (~rr + RS_W'(1)) : rr;
   endfunction

   function automatic logic signed [CW-1:0] sat_coord(input logic signed [SM_W-1:0] v);
      if (v[SM_W-1:CW-1] == '0 || v[SM_W-1:CW-1] == '1) begin
         return v[CW-1:0];
      end
      return v[SM_W-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
   endfunction

   function automatic logic signed [UW-1:0] clamp_unit(input logic signed [RS_W-1:0] v);
      if (v > RS_W'(ccb_pkg::UNIT_ONE)) return ccb_pkg::UNIT_ONE;
      if (v < -RS_W'(ccb_pkg::UNIT_ONE)) return -ccb_pkg::UNIT_ONE;
      return v[UW-1:0];
   endfunction

   logic en;
   logic out_vld_ff;

   // input register
   logic                  in_vld_ff;
   ccb_pkg::coord_type    tx_ff, ty_ff, tz_ff, hx_ff, hz_ff, hh_ff;
   logic [ccb_pkg::DIST_W-1:0] d_ff;
   // short heading test
   logic [63:0] sqx_ff, sqz_ff;
   logic        sh1_vld_ff, sh2_vld_ff, short_ff;
   logic [CW-1:0] ax, az;
   // stage A: flat heading
   logic                  na_vld, sa_vld, ss_vld, short_d;
   logic [2:0][UW-1:0]    na_o;
   ccb_pkg::coord_type    txa, tya, tza, hha;
   logic [ccb_pkg::DIST_W-1:0] da;
   ccb_pkg::unit_type     flat_x_in, flat_z_in;
   // stage B: offsets and camera position
   logic                  b1_vld_ff, b2_vld_ff, fvz1_ff, fvz2_ff;
   logic signed [OW-1:0]  ox_ff, oy_ff, oz_ff;
   ccb_pkg::coord_type    tx1_ff, ty1_ff, tz1_ff, hh1_ff;
   ccb_pkg::unit_type     fx1_ff, fz1_ff, fx2_ff, fz2_ff;
   ccb_pkg::coord_type    camx2_ff, camy2_ff, camz2_ff;
   logic                  nb_vld, sb_vld, fvzb;
   logic [2:0][UW-1:0]    nb_o;
   ccb_pkg::coord_type    camxb, camyb, camzb;
   ccb_pkg::unit_type     fxb, fzb;
   // stage C: front and right
   logic                  c1_vld_ff;
   ccb_pkg::unit_type     frx1_ff, fry1_ff, frz1_ff;
   ccb_pkg::coord_type    camx1_ff, camy1_ff, camz1_ff;
   logic                  vert_c;
   logic                  nc_vld, sc_vld, vertc;
   logic [2:0][UW-1:0]    nc_o;
   ccb_pkg::unit_type     frxc, fryc, frzc;
   ccb_pkg::coord_type    camxc, camyc, camzc;
   // stage D: up vector and output
   logic                  d1_vld_ff, d2_vld_ff;
   ccb_pkg::unit_type     rtx1_ff, rtz1_ff, frx3_ff, fry3_ff, frz3_ff;
   ccb_pkg::unit_type     rtx2_ff, rtz2_ff, frx4_ff, fry4_ff, frz4_ff;
   ccb_pkg::coord_type    camx3_ff, camy3_ff, camz3_ff, camx4_ff, camy4_ff, camz4_ff;
   logic signed [2*UW-1:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [OW-1:0]  upx_in, upy_in, upz_in;
   ccb_pkg::coord_type    camx_o_ff, camy_o_ff, camz_o_ff;
   ccb_pkg::unit_type     frx_o_ff, fry_o_ff, frz_o_ff, rtx_o_ff, rtz_o_ff;
   ccb_pkg::unit_type     upx_o_ff, upy_o_ff, upz_o_ff;

   assign en         = !out_vld_ff || rsp_tready;
   assign req_tready = en;

   // valid bits of the stages outside the normalizers and delay lines
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         sh1_vld_ff <= 1'b0;
         sh2_vld_ff <= 1'b0;
         b1_vld_ff  <= 1'b0;
         b2_vld_ff  <= 1'b0;
         c1_vld_ff  <= 1'b0;
         d1_vld_ff  <= 1'b0;
         d2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         in_vld_ff  <= req_tvalid;
         sh1_vld_ff <= in_vld_ff;
         sh2_vld_ff <= sh1_vld_ff;
         b1_vld_ff  <= na_vld;
         b2_vld_ff  <= b1_vld_ff;
         c1_vld_ff  <= nb_vld;
         d1_vld_ff  <= nc_vld;
         d2_vld_ff  <= d1_vld_ff;
         out_vld_ff <= d2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tx_ff <= req_tdata[31:0];
         ty_ff <= req_tdata[63:32];
         tz_ff <= req_tdata[95:64];
         hx_ff <= req_tdata[127:96];
         hz_ff <= req_tdata[191:160];
         d_ff  <= req_tdata[222:192];
         hh_ff <= req_tdata[254:223];
      end
   end

   // squared heading length against the short limit
   assign ax = hx_ff[CW-1] ? (~hx_ff + CW'(1)) : hx_ff;
   assign az = hz_ff[CW-1] ? (~hz_ff + CW'(1)) : hz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff   <= 64'(ax) * 64'(ax);
         sqz_ff   <= 64'(az) * 64'(az);
         short_ff <= (65'(sqx_ff) + 65'(sqz_ff)) < 65'(ccb_pkg::SHORT_LIM);
      end
   end

   ccb_norm3 #(.IW(CW)) u_norm_flat (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (in_vld_ff),
      .in_v    ({hz_ff, {CW{1'b0}}, hx_ff}),
      .out_vld (na_vld),
      .out_o   (na_o)
   );

   ccb_delay #(.W(SA_W), .DEPTH(NL)) u_side_a (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (in_vld_ff),
      .in_data  ({hh_ff, d_ff, tz_ff, ty_ff, tx_ff}),
      .out_vld  (sa_vld),
      .out_data ({hha, da, tza, tya, txa})
   );

   ccb_delay #(.W(1), .DEPTH(NL - 2)) u_side_short (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (sh2_vld_ff),
      .in_data  (short_ff),
      .out_vld  (ss_vld),
      .out_data (short_d)
   );

   // fall back to (0,0,-1) for a short heading
   assign flat_x_in = short_d ? '0 : na_o[0];
   assign flat_z_in = short_d ? -ccb_pkg::UNIT_ONE : na_o[2];

   always_ff @(posedge clock) begin
      if (en) begin
         ox_ff   <= OW'(flat_x_in) * OW'($signed({1'b0, da}));
         oz_ff   <= OW'(flat_z_in) * OW'($signed({1'b0, da}));
         oy_ff   <= -(OW'(hha) <<< ccb_pkg::UFB);
         fvz1_ff <= (da == '0) && (hha == '0);
         tx1_ff  <= txa;
         ty1_ff  <= tya;
         tz1_ff  <= tza;
         hh1_ff  <= hha;
         fx1_ff  <= flat_x_in;
         fz1_ff  <= flat_z_in;
         camx2_ff <= sat_coord(SM_W'(tx1_ff) - SM_W'(round_unit(ox_ff)));
         camy2_ff <= sat_coord(SM_W'(ty1_ff) + SM_W'(hh1_ff));
         camz2_ff <= sat_coord(SM_W'(tz1_ff) - SM_W'(round_unit(oz_ff)));
         fx2_ff   <= fx1_ff;
         fz2_ff   <= fz1_ff;
         fvz2_ff  <= fvz1_ff;
      end
   end

   ccb_norm3 #(.IW(OW)) u_norm_front (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (b1_vld_ff),
      .in_v    ({oz_ff, oy_ff, ox_ff}),
      .out_vld (nb_vld),
      .out_o   (nb_o)
   );

   ccb_delay #(.W(SB_W), .DEPTH(NL - 1)) u_side_b (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (b2_vld_ff),
      .in_data  ({fvz2_ff, fz2_ff, fx2_ff, camz2_ff, camy2_ff, camx2_ff}),
      .out_vld  (sb_vld),
      .out_data ({fvzb, fzb, fxb, camzb, camyb, camxb})
   );

   // camera on the target: front is the flat heading
   always_ff @(posedge clock) begin
      if (en) begin
         frx1_ff  <= fvzb ? fxb : nb_o[0];
         fry1_ff  <= fvzb ? '0 : nb_o[1];
         frz1_ff  <= fvzb ? fzb : nb_o[2];
         camx1_ff <= camxb;
         camy1_ff <= camyb;
         camz1_ff <= camzb;
      end
   end

   assign vert_c = (frx1_ff == '0) && (frz1_ff == '0);

   ccb_norm3 #(.IW(UW + 1)) u_norm_right (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (c1_vld_ff),
      .in_v    ({(UW+1)'(frx1_ff), {(UW+1){1'b0}}, -(UW+1)'(frz1_ff)}),
      .out_vld (nc_vld),
      .out_o   (nc_o)
   );

   ccb_delay #(.W(SC_W), .DEPTH(NL)) u_side_c (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (c1_vld_ff),
      .in_data  ({vert_c, frz1_ff, fry1_ff, frx1_ff, camz1_ff, camy1_ff, camx1_ff}),
      .out_vld  (sc_vld),
      .out_data ({vertc, frzc, fryc, frxc, camzc, camyc, camxc})
   );

   // right has no y part; vertical front takes (1,0,0)
   always_ff @(posedge clock) begin
      if (en) begin
         rtx1_ff  <= vertc ? ccb_pkg::UNIT_ONE : nc_o[0];
         rtz1_ff  <= vertc ? '0 : nc_o[2];
         frx3_ff  <= frxc;
         fry3_ff  <= fryc;
         frz3_ff  <= frzc;
         camx3_ff <= camxc;
         camy3_ff <= camyc;
         camz3_ff <= camzc;
         pa_ff    <= (2*UW)'(rtz1_ff) * (2*UW)'(fry3_ff);
         pb_ff    <= (2*UW)'(rtz1_ff) * (2*UW)'(frx3_ff);
         pc_ff    <= (2*UW)'(rtx1_ff) * (2*UW)'(frz3_ff);
         pd_ff    <= (2*UW)'(rtx1_ff) * (2*UW)'(fry3_ff);
         rtx2_ff  <= rtx1_ff;
         rtz2_ff  <= rtz1_ff;
         frx4_ff  <= frx3_ff;
         fry4_ff  <= fry3_ff;
         frz4_ff  <= frz3_ff;
         camx4_ff <= camx3_ff;
         camy4_ff <= camy3_ff;
         camz4_ff <= camz3_ff;
      end
   end

   assign upx_in = -OW'(pa_ff);
   assign upy_in = OW'(pb_ff) - OW'(pc_ff);
   assign upz_in = OW'(pd_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         camx_o_ff <= camx4_ff;
         camy_o_ff <= camy4_ff;
         camz_o_ff <= camz4_ff;
         frx_o_ff  <= frx4_ff;
         fry_o_ff  <= fry4_ff;
         frz_o_ff  <= frz4_ff;
         rtx_o_ff  <= rtx2_ff;
         rtz_o_ff  <= rtz2_ff;
         upx_o_ff  <= clamp_unit(round_unit(upx_in));
         upy_o_ff  <= clamp_unit(round_unit(upy_in));
         upz_o_ff  <= clamp_unit(round_unit(upz_in));
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {upz_o_ff, upy_o_ff, upx_o_ff, rtz_o_ff, {UW{1'b0}}, rtx_o_ff,
                        frz_o_ff, fry_o_ff, frx_o_ff, camz_o_ff, camy_o_ff, camx_o_ff};

   `CCB_ASSERT_IMPLY(a_flat_align_chk, clock, reset, 1'b1, (na_vld == sa_vld) && (na_vld == ss_vld))
   `CCB_ASSERT_IMPLY(a_front_align_chk, clock, reset, 1'b1, nb_vld == sb_vld)
   `CCB_ASSERT_IMPLY(a_right_align_chk, clock, reset, 1'b1, nc_vld == sc_vld)
   `CCB_ASSERT_NEXT(a_drain_chk, clock, reset, d2_vld_ff && en, out_vld_ff)
   `CCB_ASSERT_IMPLY(a_front_unit_chk, clock, reset, out_vld_ff, (frx_o_ff <= ccb_pkg::UNIT_ONE) && (frx_o_ff >= -ccb_pkg::UNIT_ONE))
endmodule
